[hw/rtl/sfs_pkg.sv]
`default_nettype none

package sfs_pkg;

    // Number of start frames in one start sequence.
    localparam int unsigned NUM_STARTS = 4;

    // Depth of the start link store and width of its index.
    localparam int unsigned LINK_DEPTH = 8;
    localparam int unsigned IDX_W      = 3;

    // Request kinds.
    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_FRAME = 2'd1;
    localparam logic [1:0] KIND_DMA   = 2'd2;
    localparam logic [1:0] KIND_STOP  = 2'd3;

    // Frame codes.
    localparam logic [1:0] FR_STOP  = 2'd0;
    localparam logic [1:0] FR_ENTRY = 2'd1;
    localparam logic [1:0] FR_START = 2'd2;
    localparam logic [1:0] FR_IDLE  = 2'd3;

    // Mode codes.
    localparam logic [1:0] MD_STOP  = 2'd0;
    localparam logic [1:0] MD_START = 2'd1;
    localparam logic [1:0] MD_IDLE  = 2'd2;
    localparam logic [1:0] MD_FAULT = 2'd3;

    // Event codes.
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_STOP  = 2'd1;
    localparam logic [1:0] EV_IDLE  = 2'd2;
    localparam logic [1:0] EV_FAULT = 2'd3;

    // One input request.
    typedef struct packed {
        logic [1:0] kind;
        logic       enable;
        logic       desc_error;
        logic       fifo_underflow;
        logic       total_eof;
    } item_t;

    // One result.
    typedef struct packed {
        logic [1:0]  playing_frame;
        logic [2:0]  start_index;
        logic [1:0]  mode;
        logic [1:0]  event_res;
        logic [3:0]  completed_starts;
        logic        requested;
        logic        fatal;
        logic [15:0] desc_errors;
        logic [15:0] underflow_errors;
        logic [15:0] unexpected_stops;
    } res_t;

endpackage

`default_nettype wire

[hw/rtl/stim_frame_sequencer.sv]
// Stimulator frame sequencer.
// Input channel item_valid / item_stall carries one request: a set-enable
// request, a frame-finished notice, a DMA fault status or an unexpected
// stop. Output channel res_valid / res_stall carries one result per request,
// showing the frame now playing, the mode, any event and the error counts
// as they stand after that request.
// A request enters an input register on acceptance; once the result register
// is empty or being read, the sequencing logic updates the state and loads
// the result register. The block takes one request per cycle while res_stall
// is low.
// When res_stall is high and a result is offered, the result register holds
// its content; a further request may still wait in the input register, and
// item_stall rises only when both registers are full.
// Reset empties both registers and clears the sequencing state: the stop
// frame plays, the mode is stop loop, no request is pending and all counters
// are zero. Once a fault latches, later requests still produce results but
// change nothing until reset.
`default_nettype none

module stim_frame_sequencer
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [1:0]  kind,
    input  wire logic        enable,
    input  wire logic        desc_error,
    input  wire logic        fifo_underflow,
    input  wire logic        total_eof,

    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [1:0]       playing_frame,
    output logic [2:0]       start_index,
    output logic [1:0]       mode,
    output logic [1:0]       event_res,
    output logic [3:0]       completed_starts,
    output logic             requested,
    output logic             fatal,
    output logic             lines_safe_high,
    output logic [15:0]      desc_errors,
    output logic [15:0]      underflow_errors,
    output logic [15:0]      unexpected_stops
);

    sfs_pkg::item_t item_reg;
    logic           item_full_reg, item_full_next;
    sfs_pkg::res_t  res_reg;
    sfs_pkg::res_t  res_calc;
    logic           res_valid_reg, res_valid_next;
    logic           advance;
    logic           take;

    // Handshake control for both register stages.
    assign advance        = item_full_reg && (!res_valid_reg || !res_stall);
    assign item_stall     = item_full_reg && !advance;
    assign take           = item_valid && !item_stall;
    assign item_full_next = take || (item_full_reg && !advance);
    assign res_valid_next = advance || (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_full_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            item_full_reg <= item_full_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.kind           <= kind;
            item_reg.enable         <= enable;
            item_reg.desc_error     <= desc_error;
            item_reg.fifo_underflow <= fifo_underflow;
            item_reg.total_eof      <= total_eof;
        end
    end

    // Sequencing state and its update.
    sfs_state u_state
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (item_reg),
        .res   (res_calc)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_calc;
        end
    end

    assign res_valid         = res_valid_reg;
    assign playing_frame     = res_reg.playing_frame;
    assign start_index       = res_reg.start_index;
    assign mode              = res_reg.mode;
    assign event_res         = res_reg.event_res;
    assign completed_starts  = res_reg.completed_starts;
    assign requested         = res_reg.requested;
    assign fatal             = res_reg.fatal;
    assign lines_safe_high   = res_reg.fatal;
    assign desc_errors       = res_reg.desc_errors;
    assign underflow_errors  = res_reg.underflow_errors;
    assign unexpected_stops  = res_reg.unexpected_stops;

endmodule

`default_nettype wire

[hw/rtl/sfs_state.sv]
`default_nettype none

module sfs_state
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fire,
    input  wire sfs_pkg::item_t item,
    output sfs_pkg::res_t      res
);

    logic [1:0]                        mode_reg, mode_next;
    logic [1:0]                        playing_reg, playing_next;
    logic [sfs_pkg::IDX_W-1:0]         index_reg, index_next;
    logic                              request_reg, request_next;
    logic                              fault_reg, fault_next;
    logic                              stop_start_reg, stop_start_next;
    logic [sfs_pkg::LINK_DEPTH-1:0]    start_stop_reg, start_stop_next;
    logic                              idle_stop_reg, idle_stop_next;
    logic [3:0]                        done_reg, done_next;
    logic [15:0]                       desc_cnt_reg, desc_cnt_next;
    logic [15:0]                       ufl_cnt_reg, ufl_cnt_next;
    logic [15:0]                       stop_cnt_reg, stop_cnt_next;
    logic [1:0]                        ev;
    logic                              last_start;
    logic [3:0]                        idx_plus;

    // The last start frame, or any index past it, goes on to idle unless its link to stop is set.
    assign last_start = {1'b0, index_reg} >= 4'(sfs_pkg::NUM_STARTS - 1);
    assign idx_plus   = {1'b0, index_reg} + 4'd1;

    // Next state for the request held in the input register.
    always_comb
    begin
        mode_next       = mode_reg;
        playing_next    = playing_reg;
        index_next      = index_reg;
        request_next    = request_reg;
        fault_next      = fault_reg;
        stop_start_next = stop_start_reg;
        start_stop_next = start_stop_reg;
        idle_stop_next  = idle_stop_reg;
        done_next       = done_reg;
        desc_cnt_next   = desc_cnt_reg;
        ufl_cnt_next    = ufl_cnt_reg;
        stop_cnt_next   = stop_cnt_reg;
        ev              = sfs_pkg::EV_NONE;

        if (!fault_reg)
        begin
            case (item.kind)
                sfs_pkg::KIND_SET:
                begin
                    request_next = item.enable;
                    if (item.enable)
                    begin
                        if (mode_reg == sfs_pkg::MD_STOP)
                        begin
                            start_stop_next = '0;
                            idle_stop_next  = 1'b0;
                            stop_start_next = 1'b1;
                            mode_next       = sfs_pkg::MD_START;
                            done_next       = 4'd0;
                        end
                    end
                    else
                    begin
                        stop_start_next = 1'b0;
                        idle_stop_next  = 1'b1;
                        start_stop_next = '1;
                    end
                end

                sfs_pkg::KIND_FRAME:
                begin
                    // Successors come from the links as they stood before.
                    case (playing_reg)
                        sfs_pkg::FR_STOP:
                        begin
                            if (stop_start_reg)
                            begin
                                playing_next = sfs_pkg::FR_START;
                                index_next   = '0;
                            end
                        end

                        sfs_pkg::FR_ENTRY:
                        begin
                            playing_next    = sfs_pkg::FR_STOP;
                            idle_stop_next  = 1'b0;
                            start_stop_next = '0;
                            mode_next       = sfs_pkg::MD_STOP;
                            done_next       = 4'd0;
                            if (request_reg)
                            begin
                                stop_start_next = 1'b1;
                            end
                            ev = sfs_pkg::EV_STOP;
                        end

                        sfs_pkg::FR_START:
                        begin
                            if (start_stop_reg[index_reg])
                            begin
                                playing_next = sfs_pkg::FR_ENTRY;
                            end
                            else if (!last_start)
                            begin
                                index_next = idx_plus[sfs_pkg::IDX_W-1:0];
                            end
                            else
                            begin
                                playing_next = sfs_pkg::FR_IDLE;
                            end
                            mode_next = sfs_pkg::MD_START;
                            done_next = idx_plus;
                            if (index_reg == '0)
                            begin
                                stop_start_next = 1'b0;
                            end
                            if (!request_reg)
                            begin
                                start_stop_next[index_reg] = 1'b1;
                            end
                            else if (last_start)
                            begin
                                mode_next = sfs_pkg::MD_IDLE;
                                ev        = sfs_pkg::EV_IDLE;
                            end
                        end

                        default:
                        begin
                            playing_next = idle_stop_reg ? sfs_pkg::FR_ENTRY
                                                         : sfs_pkg::FR_IDLE;
                        end
                    endcase
                end

                sfs_pkg::KIND_DMA:
                begin
                    if (item.desc_error || item.fifo_underflow || item.total_eof)
                    begin
                        if (item.desc_error && (desc_cnt_reg != 16'hFFFF))
                        begin
                            desc_cnt_next = desc_cnt_reg + 16'd1;
                        end
                        if (item.fifo_underflow && (ufl_cnt_reg != 16'hFFFF))
                        begin
                            ufl_cnt_next = ufl_cnt_reg + 16'd1;
                        end
                        if (item.total_eof && (stop_cnt_reg != 16'hFFFF))
                        begin
                            stop_cnt_next = stop_cnt_reg + 16'd1;
                        end
                        fault_next = 1'b1;
                        mode_next  = sfs_pkg::MD_FAULT;
                        ev         = sfs_pkg::EV_FAULT;
                    end
                end

                default:
                begin
                    if (stop_cnt_reg != 16'hFFFF)
                    begin
                        stop_cnt_next = stop_cnt_reg + 16'd1;
                    end
                    fault_next = 1'b1;
                    mode_next  = sfs_pkg::MD_FAULT;
                    ev         = sfs_pkg::EV_FAULT;
                end
            endcase
        end
    end

    // The result shows the state after the request.
    always_comb
    begin
        res.playing_frame     = playing_next;
        res.start_index       = index_next;
        res.mode              = mode_next;
        res.event_res         = ev;
        res.completed_starts  = done_next;
        res.requested         = request_next;
        res.fatal             = fault_next;
        res.desc_errors       = desc_cnt_next;
        res.underflow_errors  = ufl_cnt_next;
        res.unexpected_stops  = stop_cnt_next;
    end

    // State registers, updated when the request moves to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= sfs_pkg::MD_STOP;
            playing_reg    <= sfs_pkg::FR_STOP;
            index_reg      <= '0;
            request_reg    <= 1'b0;
            fault_reg      <= 1'b0;
            stop_start_reg <= 1'b0;
            start_stop_reg <= '0;
            idle_stop_reg  <= 1'b0;
            done_reg       <= 4'd0;
            desc_cnt_reg   <= 16'd0;
            ufl_cnt_reg    <= 16'd0;
            stop_cnt_reg   <= 16'd0;
        end
        else if (fire)
        begin
            mode_reg       <= mode_next;
            playing_reg    <= playing_next;
            index_reg      <= index_next;
            request_reg    <= request_next;
            fault_reg      <= fault_next;
            stop_start_reg <= stop_start_next;
            start_stop_reg <= start_stop_next;
            idle_stop_reg  <= idle_stop_next;
            done_reg       <= done_next;
            desc_cnt_reg   <= desc_cnt_next;
            ufl_cnt_reg    <= ufl_cnt_next;
            stop_cnt_reg   <= stop_cnt_next;
        end
    end

endmodule

`default_nettype wire

[verif/stim_frame_sequencer_checker.sv]
`timescale 1ns / 100ps

module stim_frame_sequencer_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    input  logic        item_stall,
    input  logic [1:0]  kind,
    input  logic        enable,
    input  logic        desc_error,
    input  logic        fifo_underflow,
    input  logic        total_eof,

    input  logic        res_valid,
    input  logic        res_stall,
    input  logic [1:0]  playing_frame,
    input  logic [2:0]  start_index,
    input  logic [1:0]  mode,
    input  logic [1:0]  event_res,
    input  logic [3:0]  completed_starts,
    input  logic        requested,
    input  logic        fatal,
    input  logic        lines_safe_high,
    input  logic [15:0] desc_errors,
    input  logic [15:0] underflow_errors,
    input  logic [15:0] unexpected_stops,

    output int          fail_count,
    output int          outstanding,
    output int          checked_count,
    output int          stop_events,
    output int          idle_events,
    output int          fault_events
);
    import sfs_pkg::*;

    // Shadow copy of the sequencer state.
    logic [1:0]            frame_q;
    logic [IDX_W-1:0]      idx_q;
    logic [1:0]            mode_q;
    logic                  req_q;
    logic                  fault_q;
    logic                  stop_to_start;
    logic [LINK_DEPTH-1:0] start_to_stop;
    logic                  idle_to_stop;
    logic [3:0]            starts_done;
    logic [15:0]           desc_cnt;
    logic [15:0]           underflow_cnt;
    logic [15:0]           stop_cnt;

    // Results predicted for accepted requests, oldest first.
    res_t result_q[$];

    function automatic logic [15:0] sat_bump(input logic [15:0] value);
        return (value == 16'hFFFF) ? value : value + 16'd1;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Apply one request to the shadow state and return the result it should produce.
    task automatic sequence_step(input logic [1:0] k, input logic en, input logic de,
                                 input logic uf, input logic te, output res_t r);
        logic [1:0]  ev;
        int unsigned slot;
        logic        last;
        ev   = EV_NONE;
        slot = idx_q;
        last = (slot + 1 >= NUM_STARTS);
        if (!fault_q)
        begin
            case (k)
                KIND_SET:
                begin
                    req_q = en;
                    if (en)
                    begin
                        // Enabling only rearms the chain from the stop loop.
                        if (mode_q == MD_STOP)
                        begin
                            start_to_stop = '0;
                            idle_to_stop  = 1'b0;
                            stop_to_start = 1'b1;
                            mode_q        = MD_START;
                            starts_done   = 4'd0;
                        end
                    end
                    else
                    begin
                        stop_to_start = 1'b0;
                        idle_to_stop  = 1'b1;
                        start_to_stop = '1;
                    end
                end
                KIND_FRAME:
                begin
                    // The successor follows the links as they stood before this request.
                    case (frame_q)
                        FR_STOP:
                        begin
                            if (stop_to_start)
                            begin
                                frame_q = FR_START;
                                idx_q   = '0;
                            end
                        end
                        FR_ENTRY:
                        begin
                            frame_q       = FR_STOP;
                            idle_to_stop  = 1'b0;
                            start_to_stop = '0;
                            mode_q        = MD_STOP;
                            starts_done   = 4'd0;
                            if (req_q)
                                stop_to_start = 1'b1;
                            ev = EV_STOP;
                        end
                        FR_START:
                        begin
                            if (start_to_stop[slot])
                                frame_q = FR_ENTRY;
                            else if (!last)
                            begin
                                frame_q = FR_START;
                                idx_q   = IDX_W'(slot + 1);
                            end
                            else
                                frame_q = FR_IDLE;
                            mode_q      = MD_START;
                            starts_done = 4'(slot + 1);
                            if (slot == 0)
                                stop_to_start = 1'b0;
                            if (!req_q)
                                start_to_stop[slot] = 1'b1;
                            else if (last)
                            begin
                                mode_q = MD_IDLE;
                                ev     = EV_IDLE;
                            end
                        end
                        default:
                        begin
                            frame_q = idle_to_stop ? FR_ENTRY : FR_IDLE;
                        end
                    endcase
                end
                KIND_DMA:
                begin
                    // A status with no flag set is harmless.
                    if (de || uf || te)
                    begin
                        if (de)
                            desc_cnt = sat_bump(desc_cnt);
                        if (uf)
                            underflow_cnt = sat_bump(underflow_cnt);
                        if (te)
                            stop_cnt = sat_bump(stop_cnt);
                        fault_q = 1'b1;
                        mode_q  = MD_FAULT;
                        ev      = EV_FAULT;
                    end
                end
                default:
                begin
                    stop_cnt = sat_bump(stop_cnt);
                    fault_q  = 1'b1;
                    mode_q   = MD_FAULT;
                    ev       = EV_FAULT;
                end
            endcase
        end

        r.playing_frame     = frame_q;
        r.start_index       = idx_q;
        r.mode              = mode_q;
        r.event_res         = ev;
        r.completed_starts  = starts_done;
        r.requested         = req_q;
        r.fatal             = fault_q;
        r.desc_errors       = desc_cnt;
        r.underflow_errors  = underflow_cnt;
        r.unexpected_stops  = stop_cnt;
    endtask

    // Compare results as they leave, then predict newly accepted requests.
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        res_t fresh;
        if (!rst_n)
        begin
            frame_q       = FR_STOP;
            idx_q         = '0;
            mode_q        = MD_STOP;
            req_q         = 1'b0;
            fault_q       = 1'b0;
            stop_to_start = 1'b0;
            start_to_stop = '0;
            idle_to_stop  = 1'b0;
            starts_done   = 4'd0;
            desc_cnt      = 16'd0;
            underflow_cnt = 16'd0;
            stop_cnt      = 16'd0;
            result_q.delete();
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result arrived with no request waiting for one");
                    fail_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("playing_frame", want.playing_frame, playing_frame);
                    check_field("start_index", want.start_index, start_index);
                    check_field("mode", want.mode, mode);
                    check_field("event_res", want.event_res, event_res);
                    check_field("completed_starts", want.completed_starts, completed_starts);
                    check_field("requested", want.requested, requested);
                    check_field("fatal", want.fatal, fatal);
                    check_field("lines_safe_high", want.fatal, lines_safe_high);
                    check_field("desc_errors", want.desc_errors, desc_errors);
                    check_field("underflow_errors", want.underflow_errors, underflow_errors);
                    check_field("unexpected_stops", want.unexpected_stops, unexpected_stops);
                    checked_count++;
                    case (want.event_res)
                        EV_STOP:  stop_events++;
                        EV_IDLE:  idle_events++;
                        EV_FAULT: fault_events++;
                        default: ;
                    endcase
                end
            end
            if (item_valid && !item_stall)
            begin
                sequence_step(kind, enable, desc_error, fifo_underflow, total_eof, fresh);
                result_q.push_back(fresh);
            end
        end
        outstanding = result_q.size();
    end

endmodule

[verif/stim_frame_sequencer_tb.sv]
`timescale 1ns / 100ps

module stim_frame_sequencer_tb;
    import sfs_pkg::*;

    localparam int DIRECTED_REQS = 25;
    localparam int PHASE_REQS    = 500;
    localparam int HOLD_CYCLES   = 60;

    logic        clk = 1'b0;
    logic        rst_n;

    logic        item_valid;
    logic        item_stall;
    logic [1:0]  kind;
    logic        enable;
    logic        desc_error;
    logic        fifo_underflow;
    logic        total_eof;

    logic        res_valid;
    logic        res_stall;
    logic [1:0]  playing_frame;
    logic [2:0]  start_index;
    logic [1:0]  mode;
    logic [1:0]  event_res;
    logic [3:0]  completed_starts;
    logic        requested;
    logic        fatal;
    logic        lines_safe_high;
    logic [15:0] desc_errors;
    logic [15:0] underflow_errors;
    logic [15:0] unexpected_stops;

    int          fail_count;
    int          outstanding;
    int          checked_count;
    int          stop_events;
    int          idle_events;
    int          fault_events;

    int          sent_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        hold_req;

    stim_frame_sequencer u_dut (.*);

    stim_frame_sequencer_checker u_checker (.*);

    always #5 clk = ~clk;

    // Run limit, far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int   hold_left;
        logic hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        res_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
                res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic logic rbit();
        return 1'($urandom_range(1));
    endfunction

    // Offer one request, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_req(input logic [1:0] k, input logic en, input logic de,
                            input logic uf, input logic te);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid     <= 1'b1;
        kind           <= k;
        enable         <= en;
        desc_error     <= de;
        fifo_underflow <= uf;
        total_eof      <= te;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sent_count++;
    endtask

    // Stray request of any harmless kind.
    task automatic send_noise();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30)
            send_req(KIND_SET, rbit(), rbit(), rbit(), rbit());
        else if (pick < 80)
            send_req(KIND_FRAME, rbit(), rbit(), rbit(), rbit());
        else
            send_req(KIND_DMA, rbit(), 1'b0, 1'b0, 1'b0);
    endtask

    // Enable, let a random number of frames finish, then usually disable and wind down.
    task automatic send_session();
        int unsigned frames;
        send_req(KIND_SET, 1'b1, rbit(), rbit(), rbit());
        frames = $urandom_range(1, 9);
        repeat (frames)
        begin
            if ($urandom_range(9) == 0)
                send_req(KIND_DMA, rbit(), 1'b0, 1'b0, 1'b0);
            send_req(KIND_FRAME, rbit(), rbit(), rbit(), rbit());
        end
        if ($urandom_range(99) < 70)
        begin
            send_req(KIND_SET, 1'b0, rbit(), rbit(), rbit());
            repeat ($urandom_range(1, 4))
                send_req(KIND_FRAME, rbit(), rbit(), rbit(), rbit());
        end
    endtask

    // Main stimulus and verdict.
    initial
    begin
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        kind           = KIND_SET;
        enable         = 1'b0;
        desc_error     = 1'b0;
        fifo_underflow = 1'b0;
        total_eof      = 1'b0;
        hold_req       = 1'b0;
        sent_count     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed walk: stop repeating, full start chain into idle, disable paths.
        send_req(KIND_FRAME, 1'b1, 1'b1, 1'b1, 1'b1);
        send_req(KIND_DMA,   1'b0, 1'b0, 1'b0, 1'b0);
        send_req(KIND_SET,   1'b0, 1'b0, 1'b0, 1'b0);
        send_req(KIND_FRAME, 1'b0, 1'b0, 1'b0, 1'b0);
        send_req(KIND_SET,   1'b1, 1'b0, 1'b0, 1'b0);
        send_req(KIND_FRAME, 1'b0, 1'b0, 1'b0, 1'b0);
        send_req(KIND_FRAME, 1'b0, 1'b0, 1'b0, 1'b0);
        send_req(KIND_FRAME, 1'b0, 1'b0, 1'b0, 1'b0);
        send_req(KIND_FRAME, 1'b0, 1'b0, 1'b0, 1'b0);
        send_req(KIND_FRAME, 1'b0, 1'b0, 1'b0, 1'b0);
        send_req(KIND_FRAME, 1'b0, 1'b0, 1'b0, 1'b0);
        send_req(KIND_SET,   1'b1, 1'b0, 1'b0, 1'b0);
        send_req(KIND_SET,   1'b0, 1'b0, 1'b0, 1'b0);
        send_req(KIND_FRAME, 1'b0, 1'b0, 1'b0, 1'b0);
        // Re-enabling while stop entry plays only stores the request.
        send_req(KIND_SET,   1'b1, 1'b0, 1'b0, 1'b0);
        send_req(KIND_FRAME, 1'b0, 1'b0, 1'b0, 1'b0);
        send_req(KIND_FRAME, 1'b0, 1'b0, 1'b0, 1'b0);
        // Disabling while the start chain plays diverts it to stop entry.
        send_req(KIND_SET,   1'b0, 1'b1, 1'b1, 1'b1);
        send_req(KIND_FRAME, 1'b0, 1'b0, 1'b0, 1'b0);
        send_req(KIND_FRAME, 1'b0, 1'b0, 1'b0, 1'b0);
        send_req(KIND_SET,   1'b1, 1'b0, 1'b0, 1'b0);
        send_req(KIND_FRAME, 1'b0, 1'b0, 1'b0, 1'b0);
        send_req(KIND_FRAME, 1'b0, 1'b0, 1'b0, 1'b0);
        send_req(KIND_SET,   1'b0, 1'b0, 1'b0, 1'b0);
        send_req(KIND_FRAME, 1'b0, 1'b0, 1'b0, 1'b0);

        // Random sessions under four traffic patterns.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            while (sent_count < DIRECTED_REQS + (ph + 1) * PHASE_REQS)
            begin
                // Back up the block once while requests keep coming.
                if (ph == 0 && sent_count >= 100 && !hold_req)
                    hold_req <= 1'b1;
                if ($urandom_range(4) == 0)
                    send_noise();
                else
                    send_session();
            end
        end

        // A fault latches for good, so it comes last, followed by ignored requests.
        send_idle_pct = 0;
        if ($urandom_range(1) == 0)
            send_req(KIND_STOP, rbit(), rbit(), rbit(), rbit());
        else
            send_req(KIND_DMA, rbit(), 1'b1, 1'b1, 1'b1);
        send_req(KIND_SET,   1'b1, 1'b0, 1'b0, 1'b0);
        send_req(KIND_FRAME, 1'b0, 1'b0, 1'b0, 1'b0);
        send_req(KIND_DMA,   1'b0, 1'b1, 1'b0, 1'b1);
        send_req(KIND_STOP,  1'b1, 1'b0, 1'b1, 1'b0);
        item_valid <= 1'b0;

        // Drain, then give stray results a chance to show up.
        recv_stall_pct = 0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("tb: %0d requests sent under four traffic patterns and one long hold-off",
                 sent_count);
        $display("tb: %0d results checked; events: %0d stop loop, %0d idle, %0d fault",
                 checked_count, stop_events, idle_events, fault_events);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/sfs_pkg.sv
hw/rtl/sfs_state.sv
hw/rtl/stim_frame_sequencer.sv
verif/stim_frame_sequencer_checker.sv
verif/stim_frame_sequencer_tb.sv
